// ===== src/biquad_cascade_filter_macros.svh =====
// Assertion helpers shared by the filter modules.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef BIQUAD_CASCADE_FILTER_MACROS_SVH
`define BIQUAD_CASCADE_FILTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BQC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BQC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/bqc_pkg.sv =====
`default_nettype none

package bqc_pkg;

    localparam int MAX_STAGES    = 8;
    localparam int SAMPLE_BITS   = 24;
    localparam int COEFF_BITS    = 32;
    localparam int COEFF_FRAC    = COEFF_BITS - 2;
    localparam int TAPS          = 5;

    // Widths of the item fields and of the register, fixed by the interface.
    localparam int ACTIVE_BITS   = 4;
    localparam int STAGE_IDX_BITS = 3;
    localparam int SEL_BITS      = 3;

    localparam int STAGE_W       = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int CNT_W         = $clog2(MAX_STAGES + 1);
    localparam int COEF_DEPTH    = MAX_STAGES * TAPS;
    localparam int COEF_AW       = $clog2(COEF_DEPTH);
    localparam int HIST_DEPTH    = 4 * MAX_STAGES;
    localparam int HIST_AW       = STAGE_W + 2;
    localparam int PROD_W        = SAMPLE_BITS + COEFF_BITS;
    localparam int ACC_W         = PROD_W + 3;
    localparam int YW            = ACC_W - COEFF_FRAC;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (COEFF_FRAC - 1);
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Item commands.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_COEF   = 1'b1;

    // Coefficient positions within one section.
    localparam logic [SEL_BITS-1:0] TAP_B0 = 3'd0;
    localparam logic [SEL_BITS-1:0] TAP_B1 = 3'd1;
    localparam logic [SEL_BITS-1:0] TAP_B2 = 3'd2;
    localparam logic [SEL_BITS-1:0] TAP_A1 = 3'd3;
    localparam logic [SEL_BITS-1:0] TAP_A2 = 3'd4;

    // Microprogram addresses.
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] STEP_IDLE = 4'd0;
    localparam logic [PC_W-1:0] STEP_T0   = 4'd1;
    localparam logic [PC_W-1:0] STEP_T1   = 4'd2;
    localparam logic [PC_W-1:0] STEP_T2   = 4'd3;
    localparam logic [PC_W-1:0] STEP_T3   = 4'd4;
    localparam logic [PC_W-1:0] STEP_T4   = 4'd5;
    localparam logic [PC_W-1:0] STEP_T5   = 4'd6;
    localparam logic [PC_W-1:0] STEP_T6   = 4'd7;
    localparam logic [PC_W-1:0] STEP_T7   = 4'd8;
    localparam logic [PC_W-1:0] STEP_OUT  = 4'd9;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_START,
        COND_MORE,
        COND_OUT,
        COND_JUMP
    } cond_t;

    // History slots of one section.
    typedef enum logic [1:0] {
        SLOT_X1,
        SLOT_X2,
        SLOT_Y1,
        SLOT_Y2
    } slot_t;

    typedef enum logic [1:0] {
        WSRC_X,
        WSRC_HOLD,
        WSRC_Y
    } wsrc_t;

    typedef struct packed {
        logic                idle;
        cond_t               cond;
        logic [PC_W-1:0]     target;
        logic [SEL_BITS-1:0] tap;
        logic                coef_next;
        slot_t               rd_slot;
        logic                mul_x;
        logic                mul_neg;
        logic                acc_en;
        logic                acc_first;
        logic                hwr_en;
        slot_t               wr_slot;
        wsrc_t               wr_src;
        logic                finish;
        logic                out_step;
    } ucode_t;

    typedef struct packed {
        logic go;
        logic zero;
        logic more;
        logic room;
    } status_t;

    // Program ROM. Memory reads are registered and so is the product, so
    // each step reads the operands of the tap that is multiplied in the next.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '0;
        case (pc)
            STEP_IDLE:
            begin
                w.idle   = 1'b1;
                w.cond   = COND_START;
                w.target = STEP_OUT;
            end
            STEP_T0:
            begin
                w.tap = TAP_B0;
            end
            STEP_T1:
            begin
                w.tap     = TAP_B1;
                w.rd_slot = SLOT_X1;
                w.mul_x   = 1'b1;
            end
            STEP_T2:
            begin
                w.tap       = TAP_B2;
                w.rd_slot   = SLOT_X2;
                w.acc_en    = 1'b1;
                w.acc_first = 1'b1;
                w.hwr_en    = 1'b1;
                w.wr_slot   = SLOT_X1;
                w.wr_src    = WSRC_X;
            end
            STEP_T3:
            begin
                w.tap     = TAP_A1;
                w.rd_slot = SLOT_Y1;
                w.acc_en  = 1'b1;
                w.hwr_en  = 1'b1;
                w.wr_slot = SLOT_X2;
                w.wr_src  = WSRC_HOLD;
            end
            STEP_T4:
            begin
                w.tap     = TAP_A2;
                w.rd_slot = SLOT_Y2;
                w.acc_en  = 1'b1;
                w.mul_neg = 1'b1;
            end
            STEP_T5:
            begin
                w.acc_en  = 1'b1;
                w.mul_neg = 1'b1;
                w.hwr_en  = 1'b1;
                w.wr_slot = SLOT_Y2;
                w.wr_src  = WSRC_HOLD;
            end
            STEP_T6:
            begin
                w.acc_en = 1'b1;
            end
            STEP_T7:
            begin
                w.finish    = 1'b1;
                w.hwr_en    = 1'b1;
                w.wr_slot   = SLOT_Y1;
                w.wr_src    = WSRC_Y;
                w.tap       = TAP_B0;
                w.coef_next = 1'b1;
                w.cond      = COND_MORE;
                w.target    = STEP_T1;
            end
            STEP_OUT:
            begin
                w.out_step = 1'b1;
                w.cond     = COND_OUT;
                w.target   = STEP_IDLE;
            end
            default:
            begin
                w.cond   = COND_JUMP;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic logic [COEF_AW-1:0] coef_addr(
        input logic [STAGE_W-1:0]  stage,
        input logic [SEL_BITS-1:0] tap
    );
        return COEF_AW'(COEF_AW'(stage) * COEF_AW'(TAPS) + COEF_AW'(tap));
    endfunction

endpackage

`default_nettype wire

// ===== src/bqc_ram.sv =====
`default_nettype none

module bqc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 40
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/bqc_seq.sv =====
`default_nettype none

module bqc_seq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bqc_pkg::status_t status,
    output      bqc_pkg::ucode_t  ctrl
);

    import bqc_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic [PC_W-1:0] pc_inc;

    assign ctrl   = ucode_rom(pc_reg);
    assign pc_inc = pc_reg + PC_W'(1);

    always_comb
    begin
        case (ctrl.cond)
            COND_NONE:  pc_next = pc_inc;
            COND_START:
            begin
                if (!status.go)
                begin
                    pc_next = pc_reg;
                end
                else if (status.zero)
                begin
                    pc_next = ctrl.target;
                end
                else
                begin
                    pc_next = pc_inc;
                end
            end
            COND_MORE:  pc_next = status.more ? ctrl.target : pc_inc;
            COND_OUT:   pc_next = status.room ? ctrl.target : pc_reg;
            COND_JUMP:  pc_next = ctrl.target;
            default:    pc_next = STEP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/bqc_dp.sv =====
`default_nettype none
`include "biquad_cascade_filter_macros.svh"

module bqc_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire bqc_pkg::ucode_t                    ctrl,
    input  wire logic                               go,
    input  wire logic                               coef_wr,
    input  wire logic [bqc_pkg::ACTIVE_BITS-1:0]    active_stages,
    input  wire logic [bqc_pkg::SAMPLE_BITS-1:0]    sample_in,
    input  wire logic [bqc_pkg::STAGE_IDX_BITS-1:0] stage_index,
    input  wire logic [bqc_pkg::SEL_BITS-1:0]       coeff_select,
    input  wire logic [bqc_pkg::COEFF_BITS-1:0]     coeff_value,
    output      logic                               more,
    output      logic [bqc_pkg::SAMPLE_BITS-1:0]    result,
    output      logic                               clip
);

    import bqc_pkg::*;

    // Sequencing state of the running sample.
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   n_next;
    logic [STAGE_W-1:0] section_reg;
    logic [STAGE_W-1:0] section_next;
    logic [COEF_AW-1:0] coef_base_reg;
    logic [COEF_AW-1:0] coef_base_next;

    // Entries not written since reset read as zero.
    logic [COEF_DEPTH-1:0] coef_valid_reg;
    logic [HIST_DEPTH-1:0] hist_valid_reg;
    logic                  coef_vld_reg;
    logic                  hist_vld_reg;

    logic                  coef_we;
    logic [COEF_AW-1:0]    coef_waddr;
    logic [COEF_AW-1:0]    coef_rbase;
    logic [COEF_AW-1:0]    coef_raddr;
    logic [COEFF_BITS-1:0] coef_rdata;
    logic [HIST_AW-1:0]    hist_raddr;
    logic [HIST_AW-1:0]    hist_waddr;
    logic [SAMPLE_BITS-1:0] hist_rdata;
    logic [SAMPLE_BITS-1:0] hist_wdata;

    logic signed [COEFF_BITS-1:0]  coef_op;
    logic signed [SAMPLE_BITS-1:0] hist_op;
    logic signed [SAMPLE_BITS-1:0] mul_a;
    logic signed [PROD_W-1:0]      prod_next;
    logic signed [PROD_W-1:0]      prod_reg;
    logic                          prod_neg_reg;
    logic signed [ACC_W-1:0]       acc_base;
    logic signed [ACC_W-1:0]       acc_term;
    logic signed [ACC_W-1:0]       acc_next;
    logic signed [ACC_W-1:0]       acc_reg;

    logic [SAMPLE_BITS-1:0] xcur_reg;
    logic [SAMPLE_BITS-1:0] xcur_next;
    logic [SAMPLE_BITS-1:0] hold_reg;
    logic                   clip_reg;
    logic                   clip_next;

    logic [YW-1:0]            y_wide;
    logic [YW-SAMPLE_BITS:0]  y_top;
    logic                     y_fits;
    logic [SAMPLE_BITS-1:0]   y_sat;

    // Coefficient writes outside the table are dropped.
    assign coef_we = coef_wr && (int'(stage_index) < MAX_STAGES)
                     && (int'(coeff_select) < TAPS);
    assign coef_waddr = coef_addr(STAGE_W'(stage_index), coeff_select);

    assign more = (CNT_W'(section_reg) + CNT_W'(1)) != n_reg;

    // The last step of a section already fetches b0 of the following one.
    assign coef_rbase = (ctrl.coef_next && more) ? coef_base_reg + COEF_AW'(TAPS)
                                                 : coef_base_reg;
    assign coef_raddr = coef_rbase + COEF_AW'(ctrl.tap);
    assign hist_raddr = {section_reg, ctrl.rd_slot};
    assign hist_waddr = {section_reg, ctrl.wr_slot};

    bqc_ram #(
        .WIDTH (COEFF_BITS),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coeff_value),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    bqc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ctrl.hwr_en),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    assign coef_op = coef_vld_reg ? $signed(coef_rdata) : '0;
    assign hist_op = hist_vld_reg ? $signed(hist_rdata) : '0;
    assign mul_a   = ctrl.mul_x ? $signed(xcur_reg) : hist_op;

    assign prod_next = mul_a * coef_op;

    assign acc_base = ctrl.acc_first ? ROUND_BIAS : acc_reg;
    assign acc_term = ACC_W'(prod_reg);
    assign acc_next = prod_neg_reg ? acc_base - acc_term : acc_base + acc_term;

    // Round half up was folded in through the bias; saturate the quotient.
    assign y_wide = acc_reg[ACC_W-1:COEFF_FRAC];
    assign y_top  = y_wide[YW-1:SAMPLE_BITS-1];
    assign y_fits = (&y_top) || !(|y_top);
    assign y_sat  = y_fits ? y_wide[SAMPLE_BITS-1:0]
                           : (acc_reg[ACC_W-1] ? SAMPLE_MIN : SAMPLE_MAX);

    always_comb
    begin
        case (ctrl.wr_src)
            WSRC_X:    hist_wdata = xcur_reg;
            WSRC_HOLD: hist_wdata = hold_reg;
            WSRC_Y:    hist_wdata = y_sat;
            default:   hist_wdata = '0;
        endcase
    end

    always_comb
    begin
        n_next         = n_reg;
        section_next   = section_reg;
        coef_base_next = coef_base_reg;
        xcur_next      = xcur_reg;
        clip_next      = clip_reg;
        if (go)
        begin
            n_next         = (int'(active_stages) > MAX_STAGES) ? CNT_W'(MAX_STAGES)
                                                                 : CNT_W'(active_stages);
            section_next   = '0;
            coef_base_next = '0;
            xcur_next      = sample_in;
            clip_next      = 1'b0;
        end
        else if (ctrl.finish)
        begin
            xcur_next = y_sat;
            clip_next = clip_reg || !y_fits;
            if (more)
            begin
                section_next   = section_reg + STAGE_W'(1);
                coef_base_next = coef_base_reg + COEF_AW'(TAPS);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg          <= '0;
            section_reg    <= '0;
            coef_base_reg  <= '0;
            coef_valid_reg <= '0;
            hist_valid_reg <= '0;
            coef_vld_reg   <= 1'b0;
            hist_vld_reg   <= 1'b0;
        end
        else
        begin
            n_reg         <= n_next;
            section_reg   <= section_next;
            coef_base_reg <= coef_base_next;
            coef_vld_reg  <= coef_valid_reg[coef_raddr];
            hist_vld_reg  <= hist_valid_reg[hist_raddr];
            if (coef_we)
            begin
                coef_valid_reg[coef_waddr] <= 1'b1;
            end
            if (ctrl.hwr_en)
            begin
                hist_valid_reg[hist_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        prod_neg_reg <= ctrl.mul_neg;
        hold_reg     <= hist_op;
        xcur_reg     <= xcur_next;
        clip_reg     <= clip_next;
        if (ctrl.acc_en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign result = xcur_reg;
    assign clip   = clip_reg;

    `BQC_ASSERT_IMPL(a_section_range, (!ctrl.idle && !ctrl.out_step), (CNT_W'(section_reg) < n_reg), "section index beyond active count")
    `BQC_ASSERT_IMPL(a_coef_idle, coef_we, ctrl.idle, "coefficient written while a sample runs")

endmodule

`default_nettype wire

// ===== src/biquad_cascade_filter.sv =====
// Cascaded biquad filter, one shared multiply-accumulate driven by a microprogram.
// A new word is accepted only in the idle step, so a sample must pass all N active
// sections and reach the output register, which waits while out_stall holds a word,
// before the next word is taken; one multiplier serves all five taps of a section.
// Coefficient words are taken one per cycle while the sequencer is idle and give no output word.
// Reset sets active_stages to 1 and makes all coefficients and histories read as zero.
`default_nettype none
`include "biquad_cascade_filter_macros.svh"

module biquad_cascade_filter (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [bqc_pkg::ACTIVE_BITS-1:0]    cfg_wdata,
    input  wire logic                               in_valid,
    output      logic                               in_stall,
    input  wire logic                               command,
    input  wire logic [bqc_pkg::SAMPLE_BITS-1:0]    sample_in,
    input  wire logic                               last_in_block,
    input  wire logic [bqc_pkg::STAGE_IDX_BITS-1:0] stage_index,
    input  wire logic [bqc_pkg::SEL_BITS-1:0]       coeff_select,
    input  wire logic [bqc_pkg::COEFF_BITS-1:0]     coeff_value,
    output      logic                               out_valid,
    input  wire logic                               out_stall,
    output      logic [bqc_pkg::SAMPLE_BITS-1:0]    sample_out,
    output      logic                               last_out,
    output      logic                               clipped
);

    import bqc_pkg::*;

    logic [ACTIVE_BITS-1:0] active_stages_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SAMPLE_BITS-1:0] sample_out_reg;
    logic                   last_out_reg;
    logic                   clipped_reg;
    logic                   last_hold_reg;

    ucode_t  ctrl;
    status_t status;

    logic                   in_accept;
    logic                   go;
    logic                   coef_wr;
    logic                   load_out;
    logic                   more;
    logic [SAMPLE_BITS-1:0] result;
    logic                   clip;

    assign in_stall  = !ctrl.idle;
    assign in_accept = in_valid && !in_stall;
    assign go        = in_accept && (command == CMD_SAMPLE);
    assign coef_wr   = in_accept && (command == CMD_COEF);

    assign status.go   = go;
    assign status.zero = (active_stages_reg == '0);
    assign status.more = more;
    assign status.room = !out_valid_reg || !out_stall;

    assign load_out = ctrl.out_step && status.room;

    bqc_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    bqc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .go            (go),
        .coef_wr       (coef_wr),
        .active_stages (active_stages_reg),
        .sample_in     (sample_in),
        .stage_index   (stage_index),
        .coeff_select  (coeff_select),
        .coeff_value   (coeff_value),
        .more          (more),
        .result        (result),
        .clip          (clip)
    );

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_stages_reg <= ACTIVE_BITS'(1);
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                active_stages_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            last_hold_reg <= last_in_block;
        end
        if (load_out)
        begin
            sample_out_reg <= result;
            last_out_reg   <= last_hold_reg;
            clipped_reg    <= clip;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign last_out   = last_out_reg;
    assign clipped    = clipped_reg;

    `BQC_ASSERT_IMPL(a_no_overwrite, (out_valid_reg && out_stall), !load_out, "output word overwritten while stalled")
    `BQC_ASSERT_NEXT(a_load_shows, load_out, out_valid_reg, "loaded output word not presented")

endmodule

`default_nettype wire

// ===== tb/bqc_filter_check.sv =====
`timescale 1ns / 100ps

module bqc_filter_check (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bqc_pkg::ACTIVE_BITS-1:0]    cfg_wdata,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic                               command,
    input  logic [bqc_pkg::SAMPLE_BITS-1:0]    sample_in,
    input  logic                               last_in_block,
    input  logic [bqc_pkg::STAGE_IDX_BITS-1:0] stage_index,
    input  logic [bqc_pkg::SEL_BITS-1:0]       coeff_select,
    input  logic [bqc_pkg::COEFF_BITS-1:0]     coeff_value,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [bqc_pkg::SAMPLE_BITS-1:0]    sample_out,
    input  logic                               last_out,
    input  logic                               clipped,
    output int                                 errors,
    output int                                 pending
);
    import bqc_pkg::*;

    localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_LO = -(longint'(1) <<< (SAMPLE_BITS - 1));
    localparam longint HALF_LSB = longint'(1) <<< (COEFF_FRAC - 1);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   last;
        logic                   clip;
    } filtered_word_t;

    logic signed [COEFF_BITS-1:0]  coef_mem [MAX_STAGES][TAPS];
    logic signed [SAMPLE_BITS-1:0] x_past   [MAX_STAGES][2];
    logic signed [SAMPLE_BITS-1:0] y_past   [MAX_STAGES][2];
    logic [ACTIVE_BITS-1:0]        stage_count;
    filtered_word_t                filtered_due [$];

    // Runs one sample through the active sections and advances their histories.
    function automatic filtered_word_t filter_sample(
        input logic signed [SAMPLE_BITS-1:0] x_in,
        input logic                          last
    );
        filtered_word_t res;
        longint         x;
        longint         acc;
        longint         y;
        int             n;
        int             s;
        res.clip = 1'b0;
        res.last = last;
        x = x_in;
        n = (int'(stage_count) > MAX_STAGES) ? MAX_STAGES : int'(stage_count);
        for (s = 0; s < n; s++)
        begin
            acc = longint'(coef_mem[s][TAP_B0]) * x
                + longint'(coef_mem[s][TAP_B1]) * longint'(x_past[s][0])
                + longint'(coef_mem[s][TAP_B2]) * longint'(x_past[s][1])
                - longint'(coef_mem[s][TAP_A1]) * longint'(y_past[s][0])
                - longint'(coef_mem[s][TAP_A2]) * longint'(y_past[s][1])
                + HALF_LSB;
            y = acc >>> COEFF_FRAC;
            if (y > SAT_HI)
            begin
                y = SAT_HI;
                res.clip = 1'b1;
            end
            else if (y < SAT_LO)
            begin
                y = SAT_LO;
                res.clip = 1'b1;
            end
            x_past[s][1] = x_past[s][0];
            x_past[s][0] = SAMPLE_BITS'(x);
            y_past[s][1] = y_past[s][0];
            y_past[s][0] = SAMPLE_BITS'(y);
            x = y;
        end
        res.sample = SAMPLE_BITS'(x);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        filtered_word_t want;
        int             s;
        int             k;
        if (!rst_n)
        begin
            for (s = 0; s < MAX_STAGES; s++)
            begin
                for (k = 0; k < TAPS; k++)
                    coef_mem[s][k] = '0;
                for (k = 0; k < 2; k++)
                begin
                    x_past[s][k] = '0;
                    y_past[s][k] = '0;
                end
            end
            stage_count = ACTIVE_BITS'(1);
            filtered_due.delete();
            errors = 0;
        end
        else
        begin
            // Outputs first, so a word accepted at this edge never matches itself.
            if (out_valid && !out_stall)
            begin
                if (filtered_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected output word, expected none, got sample_out %0d",
                             $time, $signed(sample_out));
                end
                else
                begin
                    want = filtered_due.pop_front();
                    if (sample_out !== want.sample)
                    begin
                        errors++;
                        $display("%0t: sample_out expected %0d got %0d", $time,
                                 $signed(want.sample), $signed(sample_out));
                    end
                    if (last_out !== want.last)
                    begin
                        errors++;
                        $display("%0t: last_out expected %0b got %0b", $time,
                                 want.last, last_out);
                    end
                    if (clipped !== want.clip)
                    begin
                        errors++;
                        $display("%0t: clipped expected %0b got %0b", $time,
                                 want.clip, clipped);
                    end
                end
            end
            if (cfg_we)
                stage_count = cfg_wdata;
            if (in_valid && !in_stall)
            begin
                if (command == CMD_COEF)
                begin
                    if (int'(stage_index) < MAX_STAGES && coeff_select <= TAP_A2)
                        coef_mem[stage_index][coeff_select] = coeff_value;
                end
                else
                begin
                    filtered_due.push_back(filter_sample(sample_in, last_in_block));
                end
            end
        end
        pending = filtered_due.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import bqc_pkg::*;

    localparam int     CYCLE_LIMIT   = 1_000_000;
    localparam int     SETTLE_CYCLES = 80;
    localparam int     IDLE_PCT      = 19;
    localparam int     PHASES        = 12;
    localparam int     PHASE_WORDS   = 140;
    // Selector past a2; the block must drop such a write.
    localparam logic [SEL_BITS-1:0] SEL_UNUSED = 3'd7;
    localparam longint UNITY   = longint'(1) <<< COEFF_FRAC;
    localparam longint A2_SPAN = (UNITY * 8) / 10;
    localparam longint B_SPAN  = UNITY / 2;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [ACTIVE_BITS-1:0]    cfg_wdata = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      command = CMD_SAMPLE;
    logic [SAMPLE_BITS-1:0]    sample_in = '0;
    logic                      last_in_block = 1'b0;
    logic [STAGE_IDX_BITS-1:0] stage_index = '0;
    logic [SEL_BITS-1:0]       coeff_select = '0;
    logic [COEFF_BITS-1:0]     coeff_value = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [SAMPLE_BITS-1:0]    sample_out;
    logic                      last_out;
    logic                      clipped;
    logic                      steady = 1'b0;
    int                        errors;
    int                        pending;
    int                        words_sent = 0;
    int                        cycle_count = 0;

    biquad_cascade_filter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .sample_in     (sample_in),
        .last_in_block (last_in_block),
        .stage_index   (stage_index),
        .coeff_select  (coeff_select),
        .coeff_value   (coeff_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample_out    (sample_out),
        .last_out      (last_out),
        .clipped       (clipped)
    );

    bqc_filter_check u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .sample_in     (sample_in),
        .last_in_block (last_in_block),
        .stage_index   (stage_index),
        .coeff_select  (coeff_select),
        .coeff_value   (coeff_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample_out    (sample_out),
        .last_out      (last_out),
        .clipped       (clipped),
        .errors        (errors),
        .pending       (pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Valid stays high from one word to the next unless an idle cycle is drawn.
    task automatic send_word(
        input logic                      cmd,
        input logic [SAMPLE_BITS-1:0]    x,
        input logic                      last,
        input logic [STAGE_IDX_BITS-1:0] stage,
        input logic [SEL_BITS-1:0]       sel,
        input logic [COEFF_BITS-1:0]     value
    );
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        command       <= cmd;
        sample_in     <= x;
        last_in_block <= last;
        stage_index   <= stage;
        coeff_select  <= sel;
        coeff_value   <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (!(cmd == CMD_COEF && sel > TAP_A2))
            words_sent++;
    endtask

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] x, input logic last);
        send_word(CMD_SAMPLE, x, last, STAGE_IDX_BITS'($urandom), SEL_BITS'($urandom),
                  $urandom);
    endtask

    task automatic send_coeff(
        input logic [STAGE_IDX_BITS-1:0] stage,
        input logic [SEL_BITS-1:0]       sel,
        input logic [COEFF_BITS-1:0]     value
    );
        send_word(CMD_COEF, SAMPLE_BITS'($urandom), 1'($urandom), stage, sel, value);
    endtask

    task automatic settle_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_stages(input logic [ACTIVE_BITS-1:0] count);
        settle_block();
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Picks a stable section: |a2| <= 0.8 and |a1| inside the stability triangle.
    task automatic load_calm_section(input logic [STAGE_IDX_BITS-1:0] stage);
        longint a2;
        longint a1;
        longint a1_span;
        a2 = longint'($urandom_range(32'(2 * A2_SPAN))) - A2_SPAN;
        a1_span = ((UNITY + a2) * 9) / 10;
        a1 = longint'($urandom_range(32'(2 * a1_span))) - a1_span;
        send_coeff(stage, TAP_A2, COEFF_BITS'(a2));
        send_coeff(stage, TAP_A1, COEFF_BITS'(a1));
        send_coeff(stage, TAP_B0,
                   COEFF_BITS'(longint'($urandom_range(32'(2 * B_SPAN))) - B_SPAN));
        send_coeff(stage, TAP_B1,
                   COEFF_BITS'(longint'($urandom_range(32'(2 * B_SPAN))) - B_SPAN));
        send_coeff(stage, TAP_B2,
                   COEFF_BITS'(longint'($urandom_range(32'(2 * B_SPAN))) - B_SPAN));
    endtask

    initial
    begin
        int                     plan [PHASES];
        int                     phase;
        int                     phase_end;
        int                     s;
        int                     r;
        logic                   calm;
        logic [SAMPLE_BITS-1:0] pick;
        plan = '{8, 1, 0, 15, 2, 8, 3, 9, 8, 4, 12, 5};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset one section is active with zero coefficients.
        send_sample(SAMPLE_MAX, 1'b1);
        set_stages(ACTIVE_BITS'(0));
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample('0, 1'b0);
        // Extreme coefficients drive section zero into saturation both ways.
        send_coeff(STAGE_IDX_BITS'(0), TAP_B0, 32'h7FFF_FFFF);
        send_coeff(STAGE_IDX_BITS'(0), TAP_B1, 32'h8000_0000);
        send_coeff(STAGE_IDX_BITS'(0), TAP_A1, 32'h8000_0000);
        send_coeff(STAGE_IDX_BITS'(0), SEL_UNUSED, 32'hFFFF_FFFF);
        send_coeff(STAGE_IDX_BITS'(7), TAP_A2, 32'h7FFF_FFFF);
        set_stages(ACTIVE_BITS'(1));
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample('0, 1'b0);
        // More sections than exist behaves as all of them.
        set_stages(ACTIVE_BITS'(15));
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_BITS'(1), 1'b1);

        for (phase = 0; phase < PHASES; phase++)
        begin
            calm = (phase % 4) != 3;
            steady <= (phase == 5);
            set_stages(ACTIVE_BITS'(plan[phase]));
            if (calm)
            begin
                for (s = 0; s < MAX_STAGES; s++)
                    load_calm_section(STAGE_IDX_BITS'(s));
            end
            else
            begin
                for (s = 0; s < TAPS * MAX_STAGES; s++)
                    send_coeff(STAGE_IDX_BITS'($urandom), SEL_BITS'($urandom), $urandom);
            end
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end)
            begin
                r = $urandom_range(99);
                if (r == 0)
                begin
                    settle_block();
                end
                else if (r < (calm ? 5 : 25))
                begin
                    if (calm)
                        load_calm_section(STAGE_IDX_BITS'($urandom_range(MAX_STAGES - 1)));
                    else
                        send_coeff(STAGE_IDX_BITS'($urandom), SEL_BITS'($urandom), $urandom);
                end
                else
                begin
                    r = $urandom_range(3);
                    if (r == 0)
                        pick = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
                    else if (r == 1)
                        pick = SAMPLE_BITS'(int'($urandom_range(4095)) - 2048);
                    else
                        pick = SAMPLE_BITS'($urandom);
                    send_sample(pick, $urandom_range(7) == 0);
                end
            end
        end

        settle_block();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/bqc_pkg.sv
src/bqc_ram.sv
src/bqc_seq.sv
src/bqc_dp.sv
src/biquad_cascade_filter.sv
tb/bqc_filter_check.sv
tb/tb.sv
